FILE: hdl/skf_pkg.sv
// Shared constants and types for the scalar Kalman filter.
package skf_pkg;

    // field widths
    localparam int MEAS_W    = 16;
    localparam int EST_W     = 32;
    localparam int GAIN_W    = 17;
    localparam int COV_W     = 32;
    localparam int NOISE_W   = 32;
    localparam int GAIN_FRAC = 16;
    localparam int PROD_W    = COV_W + GAIN_W;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 88;

    // configuration register map
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_NOISE     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEASUREMENT_NOISE = 1'b1;

    // defaults
    localparam int FRAC_BITS_DEF = 16;
    localparam logic [NOISE_W-1:0] PROCESS_NOISE_RST     = 32'd655;
    localparam logic [NOISE_W-1:0] MEASUREMENT_NOISE_RST = 32'd65536;

    // fixed-point constants
    localparam logic [GAIN_W-1:0] GAIN_ONE = 17'd65536;
    localparam logic [EST_W-1:0]  EST_MAX  = {1'b0, {(EST_W-1){1'b1}}};
    localparam logic [EST_W-1:0]  EST_MIN  = {1'b1, {(EST_W-1){1'b0}}};

    // control from the shell to the datapath
    typedef struct packed {
        logic start;
        logic restart;
        logic out_free;
    } t_ctl;

    // status and result from the datapath
    typedef struct packed {
        logic              idle;
        logic              done;
        logic [EST_W-1:0]  estimate;
        logic [GAIN_W-1:0] gain;
        logic [COV_W-1:0]  covariance;
    } t_res;

endpackage

FILE: hdl/skf_core.sv
// Sequenced datapath: gain divider, shared multiplier and filter state.
module skf_core import skf_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_ctl                     i_ctl,
    input  logic [NOISE_W-1:0]       i_process_noise,
    input  logic [NOISE_W-1:0]       i_measurement_noise,
    input  logic signed [MEAS_W-1:0] i_measurement,
    output t_res                     o_res
);

    localparam int MFX_W  = MEAS_W + FRAC_BITS;
    localparam int DIFF_W = ((MFX_W > EST_W) ? MFX_W : EST_W) + 1;
    localparam int ACC_W  = DIFF_W + GAIN_W;
    localparam int RMAG_W = ACC_W + 1 - GAIN_FRAC;
    localparam int SUM_W  = RMAG_W + 1;
    localparam int NUM_W  = COV_W + GAIN_FRAC + 1;
    localparam int DEN_W  = COV_W + 1;
    localparam int REM_W  = DEN_W + 1;
    localparam int CNT_W  = $clog2(GAIN_W);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(GAIN_W - 1);
    localparam logic [COV_W-1:0] COV_ONE  = COV_W'(1) << FRAC_BITS;
    localparam logic [PROD_W:0]  P_HALF   = (PROD_W+1)'(1) << (GAIN_FRAC - 1);
    localparam logic [ACC_W:0]   A_HALF   = (ACC_W+1)'(1) << (GAIN_FRAC - 1);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_PREP   = 8'b0000_0010,
        S_DIV    = 8'b0000_0100,
        S_MUL_LO = 8'b0000_1000,
        S_MUL_HI = 8'b0001_0000,
        S_MUL_P  = 8'b0010_0000,
        S_RND    = 8'b0100_0000,
        S_FIN    = 8'b1000_0000
    } t_state;

    t_state                     r_state;
    logic [COV_W-1:0]           r_p;
    logic signed [EST_W-1:0]    r_est;
    logic signed [MEAS_W-1:0]   r_meas;
    logic [COV_W-1:0]           r_p1;
    logic [DEN_W-1:0]           r_den;
    logic [REM_W-1:0]           r_rem;
    logic [GAIN_W-1:0]          r_nlo;
    logic [GAIN_W-1:0]          r_quo;
    logic [CNT_W-1:0]           r_cnt;
    logic                       r_neg;
    logic [DIFF_W-1:0]          r_mag;
    logic [PROD_W-1:0]          r_prod;
    logic [ACC_W-1:0]           r_acc;
    logic [RMAG_W-1:0]          r_rmag;
    logic [COV_W-1:0]           r_pnew;

    logic [COV_W:0]             n_sum_q;
    logic [COV_W-1:0]           n_p1;
    logic [DEN_W-1:0]           n_den;
    logic [NUM_W-1:0]           n_num;
    logic signed [DIFF_W-1:0]   n_diff;
    logic [DIFF_W-1:0]          n_mag;
    logic [REM_W-1:0]           n_rem_sh;
    logic                       n_ge;
    logic [GAIN_W-1:0]          n_gain;
    logic [GAIN_W-1:0]          n_gain_c;
    logic [COV_W-1:0]           n_mul_a;
    logic [GAIN_W-1:0]          n_mul_b;
    logic [PROD_W-1:0]          n_prod;
    logic [ACC_W:0]             n_acc_rnd;
    logic [PROD_W:0]            n_p_rnd;
    logic signed [SUM_W-1:0]    n_rmag_s;
    logic signed [SUM_W-1:0]    n_sum;
    logic [SUM_W-EST_W:0]       n_top;
    logic [EST_W-1:0]           n_est;
    logic                       n_fire;

    // predict: covariance plus process noise, saturated
    assign n_sum_q = {1'b0, r_p} + {1'b0, i_process_noise};
    assign n_p1    = n_sum_q[COV_W] ? {COV_W{1'b1}} : n_sum_q[COV_W-1:0];

    // gain numerator/denominator and innovation magnitude
    assign n_den  = {1'b0, r_p1} + {1'b0, i_measurement_noise};
    assign n_num  = {1'b0, r_p1, {GAIN_FRAC{1'b0}}} + NUM_W'(n_den[DEN_W-1:1]);
    assign n_diff = (DIFF_W'(r_meas) <<< FRAC_BITS) - DIFF_W'(r_est);
    assign n_mag  = n_diff[DIFF_W-1] ? DIFF_W'(-n_diff) : DIFF_W'(n_diff);

    // restoring divider step
    assign n_rem_sh = {r_rem[REM_W-2:0], r_nlo[GAIN_W-1]};
    assign n_ge     = n_rem_sh >= {1'b0, r_den};

    assign n_gain   = (r_quo > GAIN_ONE) ? GAIN_ONE : r_quo;
    assign n_gain_c = GAIN_ONE - n_gain;

    // shared multiplier operand select
    always_comb begin
        case (r_state)
            S_MUL_LO: begin
                n_mul_a = r_mag[COV_W-1:0];
                n_mul_b = n_gain;
            end
            S_MUL_HI: begin
                n_mul_a = COV_W'(r_mag[DIFF_W-1:COV_W]);
                n_mul_b = n_gain;
            end
            S_MUL_P: begin
                n_mul_a = r_p1;
                n_mul_b = n_gain_c;
            end
            default: begin
                n_mul_a = '0;
                n_mul_b = '0;
            end
        endcase
    end
    assign n_prod = PROD_W'(n_mul_a) * PROD_W'(n_mul_b);

    // rounding of correction and covariance
    assign n_acc_rnd = {1'b0, r_acc} + A_HALF;
    assign n_p_rnd   = {1'b0, r_prod} + P_HALF;

    // estimate update with saturation
    assign n_rmag_s = $signed({1'b0, r_rmag});
    assign n_sum    = SUM_W'(r_est) + (r_neg ? -n_rmag_s : n_rmag_s);
    assign n_top    = n_sum[SUM_W-1:EST_W-1];
    always_comb begin
        if ((&n_top) || !(|n_top)) begin
            n_est = n_sum[EST_W-1:0];
        end else if (n_sum[SUM_W-1]) begin
            n_est = EST_MIN;
        end else begin
            n_est = EST_MAX;
        end
    end

    assign n_fire = (r_state == S_FIN) && i_ctl.out_free;

    // sequencer and filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_p     <= COV_ONE;
            r_est   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_ctl.start) begin
                        r_meas  <= i_measurement;
                        r_p1    <= n_p1;
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_den <= n_den;
                    r_rem <= REM_W'(n_num[NUM_W-1:GAIN_W]);
                    r_nlo <= n_num[GAIN_W-1:0];
                    r_cnt <= DIV_LAST;
                    r_neg <= n_diff[DIFF_W-1];
                    r_mag <= n_mag;
                    if (n_den == '0) begin
                        r_quo   <= GAIN_ONE;
                        r_state <= S_MUL_LO;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem <= n_ge ? (n_rem_sh - {1'b0, r_den}) : n_rem_sh;
                    r_nlo <= {r_nlo[GAIN_W-2:0], 1'b0};
                    r_quo <= {r_quo[GAIN_W-2:0], n_ge};
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_state <= S_MUL_LO;
                    end
                end
                S_MUL_LO: begin
                    r_prod  <= n_prod;
                    r_state <= S_MUL_HI;
                end
                S_MUL_HI: begin
                    r_acc   <= ACC_W'(r_prod);
                    r_prod  <= n_prod;
                    r_state <= S_MUL_P;
                end
                S_MUL_P: begin
                    r_acc   <= r_acc + (ACC_W'(r_prod) << COV_W);
                    r_prod  <= n_prod;
                    r_state <= S_RND;
                end
                S_RND: begin
                    r_rmag  <= n_acc_rnd[ACC_W:GAIN_FRAC];
                    r_pnew  <= n_p_rnd[GAIN_FRAC +: COV_W];
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (i_ctl.out_free) begin
                        r_est   <= n_est;
                        r_p     <= r_pnew;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            // a noise write restarts the filter; the user must make it only while idle, the core does not enforce it
            if (i_ctl.restart) begin
                r_p   <= COV_ONE;
                r_est <= '0;
            end
        end
    end

    assign o_res.idle       = (r_state == S_IDLE);
    assign o_res.done       = n_fire;
    assign o_res.estimate   = n_est;
    assign o_res.gain       = n_gain;
    assign o_res.covariance = r_pnew;

endmodule

FILE: hdl/scalar_kalman_filter.sv
// Top level of the scalar Kalman filter: stream ports, noise registers, result register.
//
// Usage:
//   Input stream  s_axis_*: one signed 16-bit measurement per request.
//   Output stream m_axis_*: estimate (signed Q.F), gain (Q1.16, 65536 = 1.0)
//     and covariance (unsigned Q.F) for every measurement, in order.
//   Config port: i_cfg_wr_en/i_cfg_index/i_cfg_data write process noise
//     (index 0) or measurement noise (index 1); either write also resets the
//     covariance to 1.0 and the estimate to 0. Write only while idle.
// Sequence:
//   A measurement passes through a set-up state, the one-bit-per-cycle
//   restoring divider that forms the gain, 3 passes through the shared
//   32x17 multiplier, a rounding state and a write-back state. When p + r
//   is zero the divider is skipped. A new item is taken only after the last
//   one is written back: s_axis_tready is high only while the datapath idles.
// Reset (i_rst_n low, synchronous): noise registers return to 655 and 65536,
//   covariance to 1.0, estimate to 0, output empty.
// Back-pressure: the result waits in the output register while m_axis_tready
//   is low; the next item can still be taken and computed, and it then waits
//   in its final cycle until the output register frees up.
module scalar_kalman_filter import skf_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration write port
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [NOISE_W-1:0]     i_cfg_data,
    // measurement stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [15:0] measurement
    // result stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata    // [31:0] estimate, [48:32] gain,
                                                   // [80:49] covariance, [87:81] zero
);

    logic [NOISE_W-1:0]     r_process_noise;
    logic [NOISE_W-1:0]     r_measurement_noise;
    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;
    t_ctl                   n_ctl;
    t_res                   n_res;

    // noise registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_process_noise     <= PROCESS_NOISE_RST;
            r_measurement_noise <= MEASUREMENT_NOISE_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_PROCESS_NOISE:     r_process_noise     <= i_cfg_data;
                CFG_MEASUREMENT_NOISE: r_measurement_noise <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign n_ctl.start    = s_axis_tvalid && s_axis_tready;
    assign n_ctl.restart  = i_cfg_wr_en;
    assign n_ctl.out_free = !r_out_valid || m_axis_tready;

    skf_core #(
        .FRAC_BITS (FRAC_BITS)
    ) u_core (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_ctl               (n_ctl),
        .i_process_noise     (r_process_noise),
        .i_measurement_noise (r_measurement_noise),
        .i_measurement       ($signed(s_axis_tdata[MEAS_W-1:0])),
        .o_res               (n_res)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (n_res.done) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_res.done) begin
            r_out_data <= OUT_TDATA_W'({n_res.covariance, n_res.gain, n_res.estimate});
        end
    end

    assign s_axis_tready = n_res.idle;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule
